/* hw/rtl/dwi_pkg.sv */
// shared constants, types and address helper of the donor weighted interpolator
package dwi_pkg;

   localparam int NODE_MAX    = 4096;
   localparam int NVAR_MAX    = 8;
   localparam int STORE_DEPTH = NODE_MAX * NVAR_MAX;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int VAR_W       = 3;
   localparam int NODE_W      = 12;
   localparam int VCNT_W      = 4;
   localparam int NCNT_W      = 13;
   localparam int TOL_W       = 16;
   localparam int VALUE_W     = 32;
   localparam int WEIGHT_W    = 18;
   localparam int ACC_W       = 48;
   localparam int PROD_W      = VALUE_W + WEIGHT_W;
   // widest computed address: 3-bit variable times 13-bit stride plus node
   localparam int ADDR_W      = 17;

   localparam int REQ_DATA_W  = 120;
   localparam int RSP_DATA_W  = 88;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_DONOR = 1'b1;

   localparam logic [1:0] CSR_LAYOUT    = 2'd0;
   localparam logic [1:0] CSR_VAR_COUNT = 2'd1;
   localparam logic [1:0] CSR_NODE_CNT  = 2'd2;
   localparam logic [1:0] CSR_TOLERANCE = 2'd3;

   localparam logic LAYOUT_ROW = 1'b0;
   localparam logic LAYOUT_COL = 1'b1;

   // store read in flight, lined up with the read data
   typedef struct packed {
      logic             valid;
      logic [VAR_W-1:0] var_idx;
      logic             oob;
   } mac_cmd_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } mac_ctl_type;

   function automatic logic [ADDR_W-1:0] store_addr(
      input logic              layout,
      input logic [VCNT_W-1:0] nv,
      input logic [NCNT_W-1:0] ncount,
      input logic [NODE_W-1:0] node,
      input logic [VAR_W-1:0]  var_idx
   );
      logic [ADDR_W-1:0] row_addr;
      logic [ADDR_W-1:0] col_addr;
      row_addr = ADDR_W'(ADDR_W'(node) * ADDR_W'(nv)) + ADDR_W'(var_idx);
      col_addr = ADDR_W'(ADDR_W'(var_idx) * ADDR_W'(ncount)) + ADDR_W'(node);
      return (layout == LAYOUT_COL) ? col_addr : row_addr;
   endfunction

endpackage

/* hw/rtl/dwi_ram.sv */
// generic single write, single read ram with registered read data
module dwi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dwi_mac.sv */
// multiply, round and saturating accumulate into the per-variable partial sums
module dwi_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dwi_pkg::mac_cmd_type                 cmd,
   input  logic        [dwi_pkg::VALUE_W-1:0]   rd_data,
   input  logic signed [dwi_pkg::WEIGHT_W-1:0]  weight,
   input  dwi_pkg::mac_ctl_type                 ctl,
   output logic signed [dwi_pkg::VALUE_W-1:0]   head_sum,
   output logic                                 busy
);

   localparam int RND_W = dwi_pkg::PROD_W + 1 - 16;

   logic signed [dwi_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                              pvalid_ff, pvalid_in;
   logic [dwi_pkg::VAR_W-1:0]         pvar_ff, pvar_in;
   logic signed [dwi_pkg::ACC_W-1:0]  sums_ff [dwi_pkg::NVAR_MAX];
   logic signed [dwi_pkg::ACC_W-1:0]  sums_in [dwi_pkg::NVAR_MAX];

   logic signed [dwi_pkg::VALUE_W-1:0] value_s;
   logic signed [dwi_pkg::PROD_W:0]    biased;
   logic signed [RND_W-1:0]            rounded;
   logic signed [dwi_pkg::ACC_W:0]     acc_sum;
   logic signed [dwi_pkg::ACC_W-1:0]  acc_sat;
   logic signed [dwi_pkg::ACC_W-1:0]  head;

   // entries outside the store read as zero
   assign value_s   = cmd.oob ? '0 : $signed(rd_data);
   assign prod_in   = value_s * weight;
   assign pvalid_in = cmd.valid;
   assign pvar_in   = cmd.var_idx;

   // floor((p + 2^15) / 2^16)
   assign biased  = $signed({prod_ff[dwi_pkg::PROD_W-1], prod_ff})
                    + $signed((dwi_pkg::PROD_W+1)'(32768));
   assign rounded = biased[dwi_pkg::PROD_W:16];
   assign acc_sum = $signed({sums_ff[pvar_ff][dwi_pkg::ACC_W-1], sums_ff[pvar_ff]})
                    + (dwi_pkg::ACC_W+1)'(rounded);

   always_comb begin
      if (acc_sum[dwi_pkg::ACC_W] != acc_sum[dwi_pkg::ACC_W-1]) begin
         acc_sat = acc_sum[dwi_pkg::ACC_W] ? {1'b1, {(dwi_pkg::ACC_W-1){1'b0}}}
                                           : {1'b0, {(dwi_pkg::ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[dwi_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < dwi_pkg::NVAR_MAX; i++) begin
         sums_in[i] = sums_ff[i];
      end
      priority if (ctl.clear) begin
         for (int i = 0; i < dwi_pkg::NVAR_MAX; i++) begin
            sums_in[i] = '0;
         end
      end else if (ctl.shift) begin
         // emit walks the sums down past the head
         for (int i = 0; i < dwi_pkg::NVAR_MAX - 1; i++) begin
            sums_in[i] = sums_ff[i+1];
         end
         sums_in[dwi_pkg::NVAR_MAX-1] = '0;
      end else if (pvalid_ff) begin
         sums_in[pvar_ff] = acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         for (int i = 0; i < dwi_pkg::NVAR_MAX; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         pvalid_ff <= pvalid_in;
         for (int i = 0; i < dwi_pkg::NVAR_MAX; i++) begin
            sums_ff[i] <= sums_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pvar_ff <= pvar_in;
   end

   assign head = sums_ff[0];

   always_comb begin
      if (head[dwi_pkg::ACC_W-1:dwi_pkg::VALUE_W-1] != '0 &&
          head[dwi_pkg::ACC_W-1:dwi_pkg::VALUE_W-1] != '1) begin
         head_sum = head[dwi_pkg::ACC_W-1] ? {1'b1, {(dwi_pkg::VALUE_W-1){1'b0}}}
                                           : {1'b0, {(dwi_pkg::VALUE_W-1){1'b1}}};
      end else begin
         head_sum = head[dwi_pkg::VALUE_W-1:0];
      end
   end

   assign busy = pvalid_ff;

endmodule

/* hw/rtl/donor_weighted_interpolator.sv */
// top level of the donor weighted interpolator
//
// req channel: one word per store value or donor term; tuser says which and
// carries the cancel flag, tlast marks the last donor of a receptor.
// rsp channel: on an uncancelled last donor of a receptor, one word per variable in use
// (var_count, 1 to 8) with the receptor identity and the saturated sum;
// tlast marks the last variable, tuser the weight error status.
// csr port: write-only registers, taken at any edge with csr_we high.
// A store word or a cancelled donor is taken in idle and leaves the block ready
// for the next word. A donor term makes one store read per variable in use
// (var_count) through the single read port of the solution ram, then the
// multiply and accumulate stages drain. A last donor adds var_count emits, one
// result per cycle while the receiver keeps rsp_tready high.
// The result sits in an output register, so a new request word is taken while
// a finished result waits; a stalled receiver holds the emit sequence.
// Synchronous reset clears the partial sums, the error flag, the control
// state and the registers to their defaults; the solution ram keeps its
// contents and needs no clearing pass.
module donor_weighted_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // node_index, var_index, value, weight, proc_id, point_id, block_id, zero pad
   input  logic [dwi_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation, cancelled
   input  logic [1:0]                       req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_proc, out_point, out_block, out_var, interp_value, zero pad
   output logic [dwi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [dwi_pkg::TOL_W-1:0]        csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // request fields
   logic [dwi_pkg::NODE_W-1:0]          f_node;
   logic [dwi_pkg::VAR_W-1:0]           f_var;
   logic [dwi_pkg::VALUE_W-1:0]         f_value;
   logic signed [dwi_pkg::WEIGHT_W-1:0] f_weight;
   logic [15:0]                         f_proc;
   logic [23:0]                         f_point;
   logic [7:0]                          f_block;
   logic                                f_op;
   logic                                f_cancel;

   assign f_node   = req_tdata[11:0];
   assign f_var    = req_tdata[14:12];
   assign f_value  = req_tdata[46:15];
   assign f_weight = $signed(req_tdata[64:47]);
   assign f_proc   = req_tdata[80:65];
   assign f_point  = req_tdata[104:81];
   assign f_block  = req_tdata[112:105];
   assign f_op     = req_tuser[0];
   assign f_cancel = req_tuser[1];

   logic [1:0]                  state_ff, state_in;
   logic                        layout_ff;
   logic [dwi_pkg::VCNT_W-1:0]  vcnt_ff;
   logic [dwi_pkg::NCNT_W-1:0]  ncnt_ff;
   logic [dwi_pkg::TOL_W-1:0]   tol_ff;
   logic [dwi_pkg::VCNT_W-1:0]  iss_ff, iss_in;
   logic [dwi_pkg::VAR_W-1:0]   em_ff, em_in;
   logic                        werr_ff, werr_in;
   dwi_pkg::mac_cmd_type        rd_pend_ff, rd_pend_in;

   logic [dwi_pkg::NODE_W-1:0]          node_ff;
   logic signed [dwi_pkg::WEIGHT_W-1:0] weight_ff;
   logic                                last_ff;
   logic [15:0]                         proc_ff;
   logic [23:0]                         point_ff;
   logic [7:0]                          block_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [15:0]                         o_proc_ff;
   logic [23:0]                         o_point_ff;
   logic [7:0]                          o_block_ff;
   logic [dwi_pkg::VAR_W-1:0]           o_var_ff;
   logic [dwi_pkg::VALUE_W-1:0]         o_value_ff;
   logic                                o_status_ff;
   logic                                o_last_ff;

   logic [dwi_pkg::VCNT_W-1:0]  nv;
   logic [dwi_pkg::ADDR_W-1:0]  wr_full_addr;
   logic [dwi_pkg::ADDR_W-1:0]  rd_full_addr;
   logic                        accept;
   logic                        store_we;
   logic                        donor_take;
   logic                        issuing;
   logic                        run_done;
   logic                        load;
   logic                        emit_end;
   logic                        w_bad;
   logic signed [dwi_pkg::WEIGHT_W:0] w_ext;
   logic signed [dwi_pkg::WEIGHT_W:0] w_lo;
   logic signed [dwi_pkg::WEIGHT_W:0] w_hi;
   logic [dwi_pkg::VALUE_W-1:0]       rd_data;
   logic signed [dwi_pkg::VALUE_W-1:0] head_sum;
   logic                              mac_busy;
   dwi_pkg::mac_ctl_type              mac_ctl;

   // zero reads as one, anything above NVAR_MAX as NVAR_MAX
   always_comb begin
      if (vcnt_ff == '0) begin
         nv = dwi_pkg::VCNT_W'(1);
      end else if (vcnt_ff > dwi_pkg::VCNT_W'(dwi_pkg::NVAR_MAX)) begin
         nv = dwi_pkg::VCNT_W'(dwi_pkg::NVAR_MAX);
      end else begin
         nv = vcnt_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign wr_full_addr = dwi_pkg::store_addr(layout_ff, nv, ncnt_ff, f_node, f_var);
   assign store_we     = accept && (f_op == dwi_pkg::OP_STORE)
                         && (dwi_pkg::VCNT_W'(f_var) < nv)
                         && (wr_full_addr < dwi_pkg::ADDR_W'(dwi_pkg::STORE_DEPTH));
   assign donor_take   = accept && (f_op == dwi_pkg::OP_DONOR) && !f_cancel;

   // convex weight window widened by the tolerance
   assign w_ext = dwi_pkg::WEIGHT_W'(f_weight);
   assign w_lo  = -$signed({3'b000, tol_ff});
   assign w_hi  = $signed({3'b000, tol_ff}) + $signed((dwi_pkg::WEIGHT_W+1)'(65536));
   assign w_bad = (w_ext < w_lo) || (w_ext > w_hi);

   assign issuing      = (state_ff == ST_RUN) && (iss_ff < nv);
   assign rd_full_addr = dwi_pkg::store_addr(layout_ff, nv, ncnt_ff, node_ff,
                                             iss_ff[dwi_pkg::VAR_W-1:0]);
   assign run_done     = (state_ff == ST_RUN) && !issuing && !rd_pend_ff.valid && !mac_busy;

   assign load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign emit_end = load && (dwi_pkg::VCNT_W'(em_ff) == nv - dwi_pkg::VCNT_W'(1));

   assign mac_ctl.shift = load;
   assign mac_ctl.clear = emit_end;

   always_comb begin
      rd_pend_in.valid   = issuing;
      rd_pend_in.var_idx = iss_ff[dwi_pkg::VAR_W-1:0];
      rd_pend_in.oob     = (rd_full_addr >= dwi_pkg::ADDR_W'(dwi_pkg::STORE_DEPTH));
   end

   always_comb begin
      state_in = state_ff;
      iss_in   = iss_ff;
      em_in    = em_ff;
      werr_in  = werr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (donor_take) begin
               state_in = ST_RUN;
               iss_in   = '0;
               if (w_bad) begin
                  werr_in = 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (issuing) begin
               iss_in = iss_ff + dwi_pkg::VCNT_W'(1);
            end
            if (run_done) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
               em_in    = '0;
            end
         end
         ST_EMIT: begin
            if (load) begin
               em_in = em_ff + dwi_pkg::VAR_W'(1);
            end
            if (emit_end) begin
               state_in = ST_IDLE;
               werr_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         em_ff        <= '0;
         werr_ff      <= 1'b0;
         rd_pend_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         em_ff        <= em_in;
         werr_ff      <= werr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= dwi_pkg::LAYOUT_ROW;
         vcnt_ff   <= dwi_pkg::VCNT_W'(1);
         ncnt_ff   <= dwi_pkg::NCNT_W'(4096);
         tol_ff    <= dwi_pkg::TOL_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            dwi_pkg::CSR_LAYOUT:    layout_ff <= csr_wdata[0];
            dwi_pkg::CSR_VAR_COUNT: vcnt_ff   <= csr_wdata[dwi_pkg::VCNT_W-1:0];
            dwi_pkg::CSR_NODE_CNT:  ncnt_ff   <= csr_wdata[dwi_pkg::NCNT_W-1:0];
            dwi_pkg::CSR_TOLERANCE: tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (donor_take) begin
         node_ff   <= f_node;
         weight_ff <= f_weight;
         last_ff   <= req_tlast;
         proc_ff   <= f_proc;
         point_ff  <= f_point;
         block_ff  <= f_block;
      end
      if (load) begin
         o_proc_ff   <= proc_ff;
         o_point_ff  <= point_ff;
         o_block_ff  <= block_ff;
         o_var_ff    <= em_ff;
         o_value_ff  <= head_sum;
         o_status_ff <= werr_ff;
         o_last_ff   <= emit_end;
      end
   end

   dwi_ram #(
      .WIDTH (dwi_pkg::VALUE_W),
      .DEPTH (dwi_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (wr_full_addr[dwi_pkg::STORE_AW-1:0]),
      .wr_data (f_value),
      .rd_en   (issuing),
      .rd_addr (rd_full_addr[dwi_pkg::STORE_AW-1:0]),
      .rd_data (rd_data)
   );

   dwi_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rd_pend_ff),
      .rd_data  (rd_data),
      .weight   (weight_ff),
      .ctl      (mac_ctl),
      .head_sum (head_sum),
      .busy     (mac_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, o_value_ff, o_var_ff, o_block_ff, o_point_ff, o_proc_ff};
   assign rsp_tuser  = o_status_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

/* hw/rtl/dwi_checker.sv */
// port level checks of the donor weighted interpolator, bound to the top level
module dwi_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [dwi_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]                     req_tuser,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dwi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast,
   input logic                           csr_we,
   input logic [1:0]                     csr_index,
   input logic [dwi_pkg::TOL_W-1:0]      csr_wdata
);

   // a stalled result word holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
   else $error("stalled result word changed");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
   else $error("block not empty after reset");

   // pad bits above the value stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[dwi_pkg::RSP_DATA_W-1:83] == '0)
   else $error("result pad bits set");

   // a result never comes out the cycle after a store word was taken alone
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && req_tready && (req_tuser[0] == dwi_pkg::OP_STORE)
      |=> !rsp_tvalid)
   else $error("result caused by a store word");

endmodule

bind donor_weighted_interpolator dwi_checker u_dwi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_we     (csr_we),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

/* dv/donor_weighted_interpolator_tb.sv */
// self-checking testbench of the donor weighted interpolator: directed table, then random phases
`timescale 1ns / 100ps

module donor_weighted_interpolator_tb;
   import dwi_pkg::*;

   localparam int  SETTLE_CYCLES  = 24;
   localparam int  HOLD_CYCLES    = 300;
   localparam int  WATCHDOG_LIMIT = 2000;
   localparam int  RANDOM_WORDS   = 360;
   localparam int  PHASES         = 9;
   localparam int  MAX_PRINTED    = 40;
   localparam longint ONE_Q16     = 65536;
   localparam longint ACC_MAX     = 64'sd140737488355327;
   localparam longint ACC_MIN     = -ACC_MAX - 1;

   localparam logic [WEIGHT_W-1:0] W_ONE  = 18'h10000;
   localparam logic [WEIGHT_W-1:0] W_MAX  = 18'h1FFFF;
   localparam logic [WEIGHT_W-1:0] W_MIN  = 18'h20000;
   localparam logic [WEIGHT_W-1:0] W_NEG1 = 18'h3FFFF;
   localparam logic [WEIGHT_W-1:0] W_NEG2 = 18'h3FFFE;

   typedef enum logic {ROW_WORD, ROW_REG} plan_kind_e;

   typedef struct packed {
      logic                op;
      logic [NODE_W-1:0]   node;
      logic [VAR_W-1:0]    var_idx;
      logic [VALUE_W-1:0]  value;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic                cancel;
      logic [15:0]         proc;
      logic [23:0]         point;
      logic [7:0]          blk;
      logic                has_ref;
      logic [31:0]         ref_value;
      logic                ref_status;
   } req_word_t;

   typedef struct packed {
      logic [15:0]      proc;
      logic [23:0]      point;
      logic [7:0]       blk;
      logic [VAR_W-1:0] var_idx;
      logic [31:0]      value;
      logic             status;
      logic             last;
   } interp_result_t;

   typedef struct packed {
      plan_kind_e          kind;
      logic [1:0]          reg_idx;
      logic [15:0]         reg_val;
      logic                op;
      logic [NODE_W-1:0]   node;
      logic [VAR_W-1:0]    var_idx;
      logic [VALUE_W-1:0]  value;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic                cancel;
      logic                ids_high;
      logic                has_ref;
      logic [31:0]         ref_value;
      logic                ref_status;
   } plan_row_t;

   // fields: kind, reg, reg value, op, node, var, value, weight,
   //         last, cancel, ids high, has ref, ref value, ref status
   localparam int PLAN_LEN = 34;
   localparam plan_row_t PLAN [PLAN_LEN] = '{
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_STORE, 12'd5, 3'd0, 32'h0001_0000, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_STORE, 12'd4095, 3'd0, 32'h7FFF_FFFF, 18'd0,
        1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      // saturation at both ends of the output range
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd4095, 3'd7, 32'hFFFF_FFFF, W_MAX,
        1'b1, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_STORE, 12'd0, 3'd0, 32'h8000_0000, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd0, 3'd0, 32'd0, W_MAX,
        1'b1, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd0, 3'd0, 32'd0, W_MIN,
        1'b1, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
      // rounding of small negative products, cancelled word in between
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, W_NEG1,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, 18'd0,
        1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, W_NEG2,
        1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFE, 1'b1},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, 18'h10001,
        1'b1, 1'b0, 1'b0, 1'b1, 32'h0001_0001, 1'b0},
      // store to a variable beyond the count in use must not land on node 8
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_STORE, 12'd8, 3'd0, 32'h0002_0000, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_STORE, 12'd5, 3'd3, 32'hDEAD_BEEF, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd8, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b1, 1'b1, 32'h0002_0000, 1'b0},
      '{ROW_REG, CSR_TOLERANCE, 16'd0, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, W_NEG1,
        1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_REG, CSR_TOLERANCE, 16'hFFFF, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, 18'h30001,
        1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFF_0001, 1'b0},
      '{ROW_REG, CSR_VAR_COUNT, 16'd8, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd5, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      // a count of zero behaves as one
      '{ROW_REG, CSR_VAR_COUNT, 16'd0, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd4095, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
      // a count above the maximum behaves as the maximum
      '{ROW_REG, CSR_VAR_COUNT, 16'd15, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd4095, 3'd0, 32'd0, W_NEG1,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd7, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      // column layout with a stride that reads past the end of the store
      '{ROW_REG, CSR_LAYOUT, 16'(LAYOUT_COL), OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_REG, CSR_NODE_CNT, 16'd8191, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd4095, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_REG, CSR_NODE_CNT, 16'd1, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_STORE, 12'd3, 3'd2, 32'h0123_4567, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd4, 3'd0, 32'd0, W_ONE,
        1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{ROW_REG, CSR_NODE_CNT, 16'd4096, OP_STORE, 12'd0, 3'd0, 32'd0, 18'd0,
        1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_WORD, CSR_LAYOUT, 16'd0, OP_DONOR, 12'd4095, 3'd0, 32'd0, W_MAX,
        1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [TOL_W-1:0]      csr_wdata = '0;

   // mirror of the block
   logic [VALUE_W-1:0] sol_mem [STORE_DEPTH];
   longint             sums [NVAR_MAX] = '{default: 0};
   logic               wt_err = 1'b0;
   logic               m_layout = LAYOUT_ROW;
   logic [VCNT_W-1:0]  m_var_count = 4'd1;
   logic [NCNT_W-1:0]  m_node_count = 13'd4096;
   logic [TOL_W-1:0]   m_tol = 16'd1;

   interp_result_t pending_values [$];
   bit             seeded [STORE_DEPTH];
   req_word_t      cur_word;
   int             n_words = 0;
   int             n_errors = 0;
   bit             burst = 1'b0;
   bit             hold_rsp = 1'b0;

   donor_weighted_interpolator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned lanes_in_use();
      if (m_var_count == 0) return 1;
      if (m_var_count > NVAR_MAX) return NVAR_MAX;
      return m_var_count;
   endfunction

   function automatic int unsigned mem_addr(logic [NODE_W-1:0] node, int unsigned k);
      if (m_layout == LAYOUT_ROW) return node * lanes_in_use() + k;
      return k * m_node_count + node;
   endfunction

   function automatic void interpolate_word(req_word_t w);
      int unsigned    nv;
      int unsigned    a;
      longint         wt;
      longint         tol;
      longint         v;
      longint         s;
      interp_result_t r;
      nv = lanes_in_use();
      if (w.op == OP_STORE) begin
         if (w.var_idx < nv) begin
            a = mem_addr(w.node, w.var_idx);
            if (a < STORE_DEPTH) sol_mem[a] = w.value;
         end
         return;
      end
      if (w.cancel) return;
      wt  = longint'($signed(w.weight));
      tol = longint'(m_tol);
      if (wt < -tol || wt > ONE_Q16 + tol) wt_err = 1'b1;
      for (int unsigned k = 0; k < nv; k++) begin
         a = mem_addr(w.node, k);
         v = 0;
         if (a < STORE_DEPTH) v = longint'($signed(sol_mem[a]));
         s = sums[k] + ((v * wt + 64'sd32768) >>> 16);
         if (s > ACC_MAX) s = ACC_MAX;
         if (s < ACC_MIN) s = ACC_MIN;
         sums[k] = s;
      end
      if (!w.last) return;
      for (int unsigned k = 0; k < nv; k++) begin
         s = sums[k];
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         r.proc    = w.proc;
         r.point   = w.point;
         r.blk     = w.blk;
         r.var_idx = 3'(k);
         r.value   = s[31:0];
         r.status  = wt_err;
         r.last    = (k == nv - 1);
         if (w.has_ref && k == nv - 1) begin
            r.value  = w.ref_value;
            r.status = w.ref_status;
         end
         pending_values.push_back(r);
         sums[k] = 0;
      end
      wt_err = 1'b0;
   endfunction

   task automatic note_mismatch(string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("%0t ns: mismatch, %s", $realtime, msg);
   endtask

   task automatic check_result();
      interp_result_t e;
      if (pending_values.size() == 0) begin
         note_mismatch($sformatf("result with nothing pending, var %0d", rsp_tdata[50:48]));
         return;
      end
      e = pending_values.pop_front();
      if (rsp_tdata[15:0] !== e.proc)
         note_mismatch($sformatf("proc %h, want %h", rsp_tdata[15:0], e.proc));
      if (rsp_tdata[39:16] !== e.point)
         note_mismatch($sformatf("point %h, want %h", rsp_tdata[39:16], e.point));
      if (rsp_tdata[47:40] !== e.blk)
         note_mismatch($sformatf("block %h, want %h", rsp_tdata[47:40], e.blk));
      if (rsp_tdata[50:48] !== e.var_idx)
         note_mismatch($sformatf("var %0d, want %0d", rsp_tdata[50:48], e.var_idx));
      if (rsp_tdata[82:51] !== e.value)
         note_mismatch($sformatf("var %0d value %h, want %h", e.var_idx, rsp_tdata[82:51],
                                 e.value));
      if (rsp_tuser !== e.status)
         note_mismatch($sformatf("var %0d status %b, want %b", e.var_idx, rsp_tuser, e.status));
      if (rsp_tlast !== e.last)
         note_mismatch($sformatf("var %0d last %b, want %b", e.var_idx, rsp_tlast, e.last));
   endtask

   // mirror updates and result checks, all on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) interpolate_word(cur_word);
         if (csr_we) begin
            case (csr_index)
               CSR_LAYOUT:    m_layout     = csr_wdata[0];
               CSR_VAR_COUNT: m_var_count  = csr_wdata[VCNT_W-1:0];
               CSR_NODE_CNT:  m_node_count = csr_wdata[NCNT_W-1:0];
               CSR_TOLERANCE: m_tol        = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [NODE_W-1:0] pick_node();
      if ($urandom_range(0, 1) == 0) return NODE_W'($urandom_range(0, 15));
      return NODE_W'($urandom_range(0, 4095));
   endfunction

   // convex weights mostly, some right at the tolerance edges, some anything
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return WEIGHT_W'($urandom_range(0, 65536));
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0:       return WEIGHT_W'(-int'(m_tol) - 1);
            1:       return WEIGHT_W'(-int'(m_tol));
            2:       return WEIGHT_W'(65536 + int'(m_tol));
            default: return WEIGHT_W'(65537 + int'(m_tol));
         endcase
      end
      return WEIGHT_W'($urandom);
   endfunction

   function automatic req_word_t rand_donor();
      req_word_t w;
      w.op         = OP_DONOR;
      w.node       = pick_node();
      w.var_idx    = VAR_W'($urandom);
      w.value      = $urandom;
      w.weight     = pick_weight();
      w.last       = 1'b0;
      w.cancel     = 1'b0;
      w.proc       = 16'($urandom);
      w.point      = 24'($urandom);
      w.blk        = 8'($urandom);
      w.has_ref    = 1'b0;
      w.ref_value  = '0;
      w.ref_status = 1'b0;
      return w;
   endfunction

   function automatic req_word_t rand_store();
      req_word_t w;
      w    = rand_donor();
      w.op = OP_STORE;
      case ($urandom_range(0, 9))
         0:       w.value = 32'h7FFF_FFFF;
         1:       w.value = 32'h8000_0000;
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_word(req_word_t w);
      int gap;
      gap = burst ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_word = w;
      req_tdata  <= REQ_DATA_W'({w.blk, w.point, w.proc, w.weight, w.value, w.var_idx,
                                 w.node});
      req_tuser  <= {w.cancel, w.op};
      req_tlast  <= w.last;
      req_tvalid <= 1'b1;
      n_words++;
      do @(posedge clock); while (!req_tready);
   endtask

   // never let a donor read a store entry that was not written
   task automatic issue_word(req_word_t w);
      req_word_t   s;
      int unsigned a;
      if (w.op == OP_DONOR && !w.cancel) begin
         for (int unsigned k = 0; k < lanes_in_use(); k++) begin
            a = mem_addr(w.node, k);
            if (a < STORE_DEPTH && !seeded[a]) begin
               s = rand_store();
               s.node    = w.node;
               s.var_idx = VAR_W'(k);
               seeded[a] = 1'b1;
               send_word(s);
            end
         end
      end else if (w.op == OP_STORE && w.var_idx < lanes_in_use()) begin
         a = mem_addr(w.node, w.var_idx);
         if (a < STORE_DEPTH) seeded[a] = 1'b1;
      end
      send_word(w);
   endtask

   task automatic send_receptor();
      int        n_don;
      bit        drop;
      req_word_t w;
      repeat ($urandom_range(0, 2)) issue_word(rand_store());
      n_don = $urandom_range(1, 4);
      drop  = ($urandom_range(0, 6) == 0);
      for (int i = 0; i < n_don; i++) begin
         w = rand_donor();
         w.cancel = drop;
         w.last   = (i == n_don - 1);
         issue_word(w);
      end
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_values.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      req_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [TOL_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_regs(logic lay, logic [VCNT_W-1:0] vc, logic [NCNT_W-1:0] nc,
                            logic [TOL_W-1:0] tol);
      settle();
      write_reg(CSR_LAYOUT, TOL_W'(lay));
      write_reg(CSR_VAR_COUNT, TOL_W'(vc));
      write_reg(CSR_NODE_CNT, TOL_W'(nc));
      write_reg(CSR_TOLERANCE, tol);
   endtask

   // receiver: random back-pressure, one long hold-off on request
   initial begin : rsp_sink
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!burst && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (1 + pick_gap()) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) idle = 0;
         else idle++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("donor_weighted_interpolator_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      req_word_t w;
      plan_row_t row;
      int        phase_end;
      int        mid;
      bit        paused;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         row = PLAN[i];
         if (row.kind == ROW_REG) begin
            settle();
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            w = rand_donor();
            w.op         = row.op;
            w.node       = row.node;
            w.var_idx    = row.var_idx;
            w.value      = row.value;
            w.weight     = row.weight;
            w.last       = row.last;
            w.cancel     = row.cancel;
            w.proc       = row.ids_high ? 16'hFFFF : 16'h0;
            w.point      = row.ids_high ? 24'hFF_FFFF : 24'h0;
            w.blk        = row.ids_high ? 8'hFF : 8'h0;
            w.has_ref    = row.has_ref;
            w.ref_value  = row.ref_value;
            w.ref_status = row.ref_status;
            issue_word(w);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: load_regs(LAYOUT_ROW, 4'd8, 13'd4096, 16'd0);
            1: load_regs(LAYOUT_COL, 4'd8, 13'd4096, 16'hFFFF);
            2: load_regs(LAYOUT_COL, 4'd3, 13'd1, 16'($urandom));
            3: load_regs(LAYOUT_COL, 4'd15, 13'd8191, 16'($urandom));
            4: load_regs(LAYOUT_ROW, 4'd0, 13'($urandom), 16'($urandom));
            8: load_regs(LAYOUT_COL, 4'($urandom), 13'd0, 16'($urandom));
            default: load_regs(1'($urandom), 4'($urandom), 13'($urandom), 16'($urandom));
         endcase
         // long receiver hold-off while words keep coming
         if (ph == 5) hold_rsp = 1'b1;
         burst     = (ph == 7);
         phase_end = n_words + RANDOM_WORDS / PHASES;
         mid       = n_words + RANDOM_WORDS / (2 * PHASES);
         paused    = 1'b0;
         while (n_words < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               w = rand_donor();
               w.op     = 1'($urandom);
               w.cancel = 1'($urandom);
               w.last   = 1'($urandom);
               w.weight = WEIGHT_W'($urandom);
               issue_word(w);
            end else begin
               send_receptor();
            end
            // in phase 6 the sender waits for every pending result mid-phase
            if (ph == 6 && !paused && n_words >= mid) begin
               req_idle();
               wait_drained();
               paused = 1'b1;
            end
         end
      end
      burst = 1'b0;

      settle();
      if (n_errors == 0) begin
         $display("donor_weighted_interpolator_tb: done, clean");
      end else begin
         $display("donor_weighted_interpolator_tb: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/dwi_pkg.sv
hw/rtl/dwi_ram.sv
hw/rtl/dwi_mac.sv
hw/rtl/donor_weighted_interpolator.sv
hw/rtl/dwi_checker.sv
dv/donor_weighted_interpolator_tb.sv
